// ===== sv/cfrx_pkg.sv =====
package cfrx_pkg;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_SLAVE  = 3'd1,
		PH_CMD    = 3'd2,
		PH_LEN    = 3'd3,
		PH_DATA   = 3'd4,
		PH_SUM_HI = 3'd5,
		PH_SUM_LO = 3'd6,
		PH_END    = 3'd7
	} phase_t;

	localparam logic [1:0] REG_START_MARKER = 2'd0;
	localparam logic [1:0] REG_END_MARKER   = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

	localparam logic [7:0] START_MARKER_RST = 8'd58;
	localparam logic [7:0] END_MARKER_RST   = 8'd13;
	localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd64;

	typedef struct packed {
		logic [7:0]  start_marker;
		logic [7:0]  end_marker;
		logic [7:0]  max_payload;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  slave_address;
		logic [7:0]  command;
		logic [7:0]  payload_length;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic        frame_done;
		logic        frame_valid;
		logic [15:0] frame_checksum;
	} result_t;

endpackage

// ===== sv/cfrx_core.sv =====
module cfrx_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	input  cfrx_pkg::cfg_t    cfg,
	output logic              res_valid,
	output cfrx_pkg::result_t res
);

	cfrx_pkg::phase_t phase_q;
	cfrx_pkg::phase_t phase_next;

	logic [7:0]  slave_q;
	logic [7:0]  command_q;
	logic [7:0]  length_q;
	logic [7:0]  count_q;
	logic [15:0] running_sum_q;
	logic [15:0] received_sum_q;

	logic [15:0] sum_add;
	logic [8:0]  count_inc;
	logic        len_too_big;
	logic        frame_ok;

	assign sum_add     = running_sum_q + {8'd0, rx_byte};
	assign count_inc   = {1'b0, count_q} + 9'd1;
	assign len_too_big = rx_byte > cfg.max_payload;
	assign frame_ok    = (rx_byte == cfg.end_marker) && (sum_add == received_sum_q);

	always_comb begin
		phase_next = phase_q;
		unique case (phase_q)
			cfrx_pkg::PH_HUNT: begin
				if (rx_byte == cfg.start_marker) begin
					phase_next = cfrx_pkg::PH_SLAVE;
				end
			end
			cfrx_pkg::PH_SLAVE:  phase_next = cfrx_pkg::PH_CMD;
			cfrx_pkg::PH_CMD:    phase_next = cfrx_pkg::PH_LEN;
			cfrx_pkg::PH_LEN: begin
				if (len_too_big) begin
					phase_next = cfrx_pkg::PH_HUNT;
				end else if (rx_byte == 8'd0) begin
					phase_next = cfrx_pkg::PH_SUM_HI;
				end else begin
					phase_next = cfrx_pkg::PH_DATA;
				end
			end
			cfrx_pkg::PH_DATA: begin
				if (count_inc >= {1'b0, length_q}) begin
					phase_next = cfrx_pkg::PH_SUM_HI;
				end
			end
			cfrx_pkg::PH_SUM_HI: phase_next = cfrx_pkg::PH_SUM_LO;
			cfrx_pkg::PH_SUM_LO: phase_next = cfrx_pkg::PH_END;
			cfrx_pkg::PH_END:    phase_next = cfrx_pkg::PH_HUNT;
			default:             phase_next = cfrx_pkg::PH_HUNT;
		endcase
	end

	always_comb begin
		res_valid          = 1'b0;
		res.slave_address  = slave_q;
		res.command        = command_q;
		res.payload_length = length_q;
		res.payload_byte   = 8'd0;
		res.byte_index     = 8'd0;
		res.frame_done     = 1'b0;
		res.frame_valid    = 1'b0;
		res.frame_checksum = 16'd0;
		unique case (phase_q)
			cfrx_pkg::PH_LEN: begin
				res_valid          = accept && len_too_big;
				res.payload_length = rx_byte;
				res.frame_done     = 1'b1;
			end
			cfrx_pkg::PH_DATA: begin
				res_valid        = accept;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
			end
			cfrx_pkg::PH_END: begin
				res_valid          = accept;
				res.frame_done     = 1'b1;
				res.frame_valid    = frame_ok;
				res.frame_checksum = frame_ok ? received_sum_q : 16'd0;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= cfrx_pkg::PH_HUNT;
			slave_q        <= 8'd0;
			command_q      <= 8'd0;
			length_q       <= 8'd0;
			count_q        <= 8'd0;
			running_sum_q  <= 16'd0;
			received_sum_q <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_next;
			case (phase_q)
				cfrx_pkg::PH_HUNT: begin
					if (rx_byte == cfg.start_marker) begin
						running_sum_q  <= {8'd0, rx_byte};
						count_q        <= 8'd0;
						received_sum_q <= 16'd0;
					end
				end
				cfrx_pkg::PH_SLAVE: begin
					slave_q       <= rx_byte;
					running_sum_q <= sum_add;
				end
				cfrx_pkg::PH_CMD: begin
					command_q     <= rx_byte;
					running_sum_q <= sum_add;
				end
				cfrx_pkg::PH_LEN: begin
					length_q      <= rx_byte;
					running_sum_q <= sum_add;
					count_q       <= 8'd0;
				end
				cfrx_pkg::PH_DATA: begin
					running_sum_q <= sum_add;
					count_q       <= count_inc[7:0];
				end
				cfrx_pkg::PH_SUM_HI: received_sum_q <= {rx_byte, 8'd0};
				cfrx_pkg::PH_SUM_LO: received_sum_q <= {received_sum_q[15:8], rx_byte};
				default:             running_sum_q  <= sum_add;
			endcase
		end
	end

endmodule

// ===== sv/checksummed_frame_receiver.sv =====
// Serial frame receiver with a 16-bit additive checksum. One received byte
// is taken per clock cycle unless in_stall is high; header bytes, checksum
// bytes and bytes outside a frame yield nothing, each payload byte yields
// one result, and the end byte (or an oversized length) yields one status
// result. Results leave through an output register backed by a one-entry
// skid register, so the input side stalls only while the skid register is
// full. Configuration writes are always ready and are registered.
module checksummed_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  slave_address,
	output logic [7:0]  command,
	output logic [7:0]  payload_length,
	output logic [7:0]  payload_byte,
	output logic [7:0]  byte_index,
	output logic        frame_done,
	output logic        frame_valid,
	output logic [15:0] frame_checksum
);

	cfrx_pkg::cfg_t    cfg_q;
	cfrx_pkg::result_t res;
	cfrx_pkg::result_t out_q;
	cfrx_pkg::result_t skid_q;

	logic res_valid;
	logic accept;
	logic out_valid_q;
	logic skid_valid_q;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker <= cfrx_pkg::START_MARKER_RST;
			cfg_q.end_marker   <= cfrx_pkg::END_MARKER_RST;
			cfg_q.max_payload  <= cfrx_pkg::MAX_PAYLOAD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cfrx_pkg::REG_START_MARKER: cfg_q.start_marker <= cfg_data;
				cfrx_pkg::REG_END_MARKER:   cfg_q.end_marker   <= cfg_data;
				cfrx_pkg::REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_data;
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	cfrx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign slave_address  = out_q.slave_address;
	assign command        = out_q.command;
	assign payload_length = out_q.payload_length;
	assign payload_byte   = out_q.payload_byte;
	assign byte_index     = out_q.byte_index;
	assign frame_done     = out_q.frame_done;
	assign frame_valid    = out_q.frame_valid;
	assign frame_checksum = out_q.frame_checksum;

endmodule

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLDOFF_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_BUDGET   = 280;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  slave_address;
	logic [7:0]  command;
	logic [7:0]  payload_length;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic        frame_done;
	logic        frame_valid;
	logic [15:0] frame_checksum;

	checksummed_frame_receiver dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	logic [7:0] cfg_start = cfrx_pkg::START_MARKER_RST;
	logic [7:0] cfg_end   = cfrx_pkg::END_MARKER_RST;
	logic [7:0] cfg_max   = cfrx_pkg::MAX_PAYLOAD_RST;

	cfrx_pkg::phase_t rx_phase = cfrx_pkg::PH_HUNT;
	logic [7:0]  cur_slave  = '0;
	logic [7:0]  cur_cmd    = '0;
	logic [7:0]  cur_len    = '0;
	logic [7:0]  data_count = '0;
	logic [15:0] sum_acc    = '0;
	logic [15:0] sum_rx     = '0;

	logic [7:0]        pending_bytes[$];
	cfrx_pkg::result_t awaited_results[$];
	int         bytes_queued = 0;
	int         mismatches = 0;
	int         quiet_cycles = 0;
	int         send_idle_pct = 29;
	int         recv_idle_pct = 74;
	bit         pressure_armed = 1'b0;
	bit         holdoff_used = 1'b0;
	int         holdoff_left = 0;

	function automatic cfrx_pkg::result_t make_result(input logic [7:0] data,
			input logic [7:0] idx, input logic done, input logic ok, input logic [15:0] sum);
		cfrx_pkg::result_t r;
		r.slave_address  = cur_slave;
		r.command        = cur_cmd;
		r.payload_length = cur_len;
		r.payload_byte   = data;
		r.byte_index     = idx;
		r.frame_done     = done;
		r.frame_valid    = ok;
		r.frame_checksum = sum;
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		logic ok;
		case (rx_phase)
			cfrx_pkg::PH_HUNT: begin
				if (b == cfg_start) begin
					sum_acc    = {8'h00, b};
					data_count = '0;
					sum_rx     = '0;
					rx_phase   = cfrx_pkg::PH_SLAVE;
				end
			end
			cfrx_pkg::PH_SLAVE: begin
				cur_slave = b;
				sum_acc   = sum_acc + b;
				rx_phase  = cfrx_pkg::PH_CMD;
			end
			cfrx_pkg::PH_CMD: begin
				cur_cmd  = b;
				sum_acc  = sum_acc + b;
				rx_phase = cfrx_pkg::PH_LEN;
			end
			cfrx_pkg::PH_LEN: begin
				cur_len    = b;
				sum_acc    = sum_acc + b;
				data_count = '0;
				if (b > cfg_max) begin
					rx_phase = cfrx_pkg::PH_HUNT;
					awaited_results.push_back(make_result(8'h00, 8'h00, 1'b1, 1'b0, 16'h0000));
				end else begin
					rx_phase = (b == 8'h00) ? cfrx_pkg::PH_SUM_HI : cfrx_pkg::PH_DATA;
				end
			end
			cfrx_pkg::PH_DATA: begin
				sum_acc = sum_acc + b;
				awaited_results.push_back(make_result(b, data_count, 1'b0, 1'b0, 16'h0000));
				data_count = data_count + 8'd1;
				if (data_count >= cur_len)
					rx_phase = cfrx_pkg::PH_SUM_HI;
			end
			cfrx_pkg::PH_SUM_HI: begin
				sum_rx   = {b, 8'h00};
				rx_phase = cfrx_pkg::PH_SUM_LO;
			end
			cfrx_pkg::PH_SUM_LO: begin
				sum_rx   = sum_rx | {8'h00, b};
				rx_phase = cfrx_pkg::PH_END;
			end
			default: begin
				sum_acc  = sum_acc + b;
				ok       = (b == cfg_end) && (sum_acc == sum_rx);
				rx_phase = cfrx_pkg::PH_HUNT;
				awaited_results.push_back(make_result(8'h00, 8'h00, 1'b1, ok,
					ok ? sum_rx : 16'h0000));
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				parse_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, label, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : monitor
		cfrx_pkg::result_t seen;
		cfrx_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = {slave_address, command, payload_length, payload_byte, byte_index,
					frame_done, frame_valid, frame_checksum};
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h", $time, seen);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("slave_address", 16'(want.slave_address),
						16'(seen.slave_address));
					check_field("command", 16'(want.command), 16'(seen.command));
					check_field("payload_length", 16'(want.payload_length),
						16'(seen.payload_length));
					check_field("payload_byte", 16'(want.payload_byte),
						16'(seen.payload_byte));
					check_field("byte_index", 16'(want.byte_index), 16'(seen.byte_index));
					check_field("frame_done", 16'(want.frame_done), 16'(seen.frame_done));
					check_field("frame_valid", 16'(want.frame_valid), 16'(seen.frame_valid));
					check_field("frame_checksum", want.frame_checksum, seen.frame_checksum);
				end
			end
			if (pressure_armed && !holdoff_used) begin
				holdoff_left = HOLDOFF_CYCLES;
				holdoff_used = 1'b1;
			end
			if (holdoff_left > 0) begin
				out_stall <= 1'b1;
				holdoff_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("checksummed_frame_receiver verification failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic queue_frame(input logic [7:0] slave, input logic [7:0] cmd,
			input logic [7:0] len, input bit bad_sum, input bit bad_end);
		logic [15:0] sum;
		logic [7:0]  b;
		logic [7:0]  tail;
		tail = bad_end ? (cfg_end ^ 8'($urandom_range(255, 1))) : cfg_end;
		sum  = cfg_start + slave + cmd + len + tail;
		queue_byte(cfg_start);
		queue_byte(slave);
		queue_byte(cmd);
		queue_byte(len);
		if (len > cfg_max)
			return;
		for (int i = 0; i < len; i++) begin
			b   = 8'($urandom_range(255));
			sum = sum + b;
			queue_byte(b);
		end
		if (bad_sum)
			sum = sum ^ (16'h0001 << $urandom_range(15));
		queue_byte(sum[15:8]);
		queue_byte(sum[7:0]);
		queue_byte(tail);
	endtask

	task automatic run_traffic(input int budget);
		int         stop_at;
		int         pick;
		int         len_pick;
		logic [7:0] len;
		logic [7:0] short_max;
		logic [7:0] noise;
		stop_at   = bytes_queued + budget;
		short_max = (cfg_max < 8'd6) ? cfg_max : 8'd6;
		while (bytes_queued < stop_at) begin
			pick     = $urandom_range(99);
			len_pick = $urandom_range(19);
			if (len_pick == 0)
				len = cfg_max;
			else if (len_pick < 3)
				len = 8'($urandom_range(cfg_max));
			else
				len = 8'($urandom_range(short_max));
			if (pick < 8) begin
				repeat ($urandom_range(4, 1)) begin
					noise = 8'($urandom_range(255));
					if (noise == cfg_start)
						noise = ~noise;
					queue_byte(noise);
				end
			end else if (pick < 16 && cfg_max != 8'hFF) begin
				queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255, cfg_max + 1)), 1'b0, 1'b0);
			end else if (pick < 22) begin
				queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
					1'b1, 1'b0);
			end else if (pick < 28) begin
				queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
					1'b0, 1'b1);
			end else if (pick < 31) begin
				queue_byte(cfg_start);
				repeat ($urandom_range(3, 1))
					queue_byte(8'($urandom_range(255)));
			end else begin
				queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
					1'b0, 1'b0);
			end
		end
	endtask

	task automatic settle();
		while (pending_bytes.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cfrx_pkg::REG_START_MARKER: cfg_start = value;
			cfrx_pkg::REG_END_MARKER:   cfg_end   = value;
			cfrx_pkg::REG_MAX_PAYLOAD:  cfg_max   = value;
			default: ;
		endcase
	endtask

	task automatic program_markers(input logic [7:0] start_value,
			input logic [7:0] end_value, input logic [7:0] max_value);
		write_reg(cfrx_pkg::REG_START_MARKER, start_value);
		write_reg(cfrx_pkg::REG_END_MARKER, end_value);
		write_reg(cfrx_pkg::REG_MAX_PAYLOAD, max_value);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_frame(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
		queue_frame(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0);
		queue_frame(8'h12, 8'h34, 8'h01, 1'b1, 1'b0);
		queue_frame(8'h01, 8'h02, 8'h00, 1'b0, 1'b1);

		settle();
		program_markers(8'hA5, 8'h5A, 8'd16);
		run_traffic(PHASE_BUDGET);

		settle();
		send_idle_pct = 74;
		recv_idle_pct = 29;
		program_markers(8'h00, 8'hFF, 8'h00);
		run_traffic(PHASE_BUDGET);

		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_markers(8'hFF, 8'h00, 8'hFF);
		write_reg(REG_UNUSED, 8'($urandom_range(255)));
		pressure_armed = 1'b1;
		run_traffic(PHASE_BUDGET);

		settle();
		if (mismatches == 0)
			$display("checksummed_frame_receiver verification clean");
		else
			$display("checksummed_frame_receiver verification failed");
		$finish;
	end

endmodule
